// ===== rtl/slfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types and constants of the sync/length frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] SYNC_BYTE     = 8'hAA;
	localparam logic [7:0] ACK_ZERO_BYTE = 8'h00;
	localparam logic [7:0] ACK_LEN_BYTE  = 8'h02;
	localparam logic [7:0] ACK_CMD_BYTE  = 8'h14;

	localparam logic       KIND_FRAME = 1'b0;
	localparam logic       KIND_ACK   = 1'b1;

	localparam int unsigned CNT_W       = 9;
	localparam logic [CNT_W-1:0] CNT_LEN  = 9'd3;
	localparam logic [CNT_W-1:0] CNT_CODE = 9'd4;
	localparam logic [CNT_W-1:0] HDR_LEN  = 9'd4;

	// one classified frame byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       ends;
		logic       ack;
		logic [7:0] code;
	} cmd_t;

endpackage

// ===== rtl/slfp_front.sv =====
// ----------------------------------------------------------------------------
// slfp_front
// Hunts for sync, counts frame bytes and classifies each byte taken.
// ----------------------------------------------------------------------------
module slfp_front import slfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] rx_byte,
	output logic       wr_en,
	output cmd_t       wr_data
);

	logic             in_frame_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       length_low_q;
	logic [7:0]       event_code_q;

	logic             accept;
	logic             take;
	logic [CNT_W-1:0] cnt_next;
	logic [7:0]       len_eff;
	logic [7:0]       code_eff;
	logic             ends;

	assign accept   = push & ~full;
	assign take     = accept & (in_frame_q | (rx_byte == SYNC_BYTE));
	assign cnt_next = in_frame_q ? byte_count_q + CNT_W'(1) : CNT_W'(1);
	assign len_eff  = (cnt_next == CNT_LEN) ? rx_byte : length_low_q;
	assign code_eff = (cnt_next == CNT_CODE) ? rx_byte : event_code_q;
	assign ends     = (cnt_next >= HDR_LEN) &&
	                  (cnt_next >= HDR_LEN + {1'b0, len_eff});

	assign wr_en        = take;
	assign wr_data.data = rx_byte;
	assign wr_data.ends = ends;
	assign wr_data.ack  = code_eff != 8'h00;
	assign wr_data.code = code_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			byte_count_q <= '0;
			length_low_q <= '0;
			event_code_q <= '0;
		end else if (take) begin
			length_low_q <= len_eff;
			event_code_q <= code_eff;
			if (ends) begin
				in_frame_q   <= 1'b0;
				byte_count_q <= '0;
			end else begin
				in_frame_q   <= 1'b1;
				byte_count_q <= cnt_next;
			end
		end
	end

endmodule

// ===== rtl/slfp_queue.sv =====
// ----------------------------------------------------------------------------
// slfp_queue
// Short register queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module slfp_queue import slfp_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic full,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

	cmd_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full    = count_q == CNT_FULL;
	assign empty   = count_q == '0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

// ===== rtl/slfp_back.sv =====
// ----------------------------------------------------------------------------
// slfp_back
// Passes frame bytes on and plays out the acknowledge frame after a frame end.
// ----------------------------------------------------------------------------
module slfp_back import slfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_data,
	output logic       q_rd,
	input  logic       pop,
	output logic       empty,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       frame_last,
	output logic       run_last
);

	localparam logic [2:0] STEP_IDLE = 3'd0;
	localparam logic [2:0] STEP_SYNC = 3'd1;
	localparam logic [2:0] STEP_ZERO = 3'd2;
	localparam logic [2:0] STEP_LEN  = 3'd3;
	localparam logic [2:0] STEP_CMD  = 3'd4;
	localparam logic [2:0] STEP_CODE = 3'd5;
	localparam logic [2:0] STEP_SUM  = 3'd6;

	logic [2:0] step_q;
	logic [7:0] code_q;
	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       flast_q;
	logic       rlast_q;

	logic       load;
	logic       busy;
	logic [7:0] ack_byte;

	assign load = ~out_valid_q | pop;
	assign busy = step_q != STEP_IDLE;
	assign q_rd = load & ~busy & ~q_empty;

	always_comb begin
		case (step_q)
			STEP_SYNC: ack_byte = SYNC_BYTE;
			STEP_ZERO: ack_byte = ACK_ZERO_BYTE;
			STEP_LEN:  ack_byte = ACK_LEN_BYTE;
			STEP_CMD:  ack_byte = ACK_CMD_BYTE;
			STEP_CODE: ack_byte = code_q;
			STEP_SUM:  ack_byte = 8'h00 - (ACK_LEN_BYTE + ACK_CMD_BYTE + code_q);
			default:   ack_byte = ACK_ZERO_BYTE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && busy) begin
			kind_q  <= KIND_ACK;
			byte_q  <= ack_byte;
			flast_q <= step_q == STEP_SUM;
			rlast_q <= step_q == STEP_SUM;
		end else if (q_rd) begin
			kind_q  <= KIND_FRAME;
			byte_q  <= q_data.data;
			flast_q <= q_data.ends;
			rlast_q <= ~(q_data.ends & q_data.ack);
			code_q  <= q_data.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= busy | q_rd;
			if (busy) begin
				step_q <= (step_q == STEP_SUM) ? STEP_IDLE : step_q + 3'd1;
			end else if (q_rd && q_data.ends && q_data.ack) begin
				step_q <= STEP_SYNC;
			end
		end
	end

	assign empty      = ~out_valid_q;
	assign out_kind   = kind_q;
	assign out_byte   = byte_q;
	assign frame_last = flast_q;
	assign run_last   = rlast_q;

endmodule

// ===== rtl/sync_length_frame_parser_with_ack.sv =====
// A frame byte goes through the queue and the back part's output register to the result ports.
// Throughput: one result per cycle while popped; a nonzero-code frame end makes seven results.
// The acknowledge sequencer in the back part sets the rate: it reads no queue byte while busy.
// The front takes a byte every cycle while the queue between the two parts has room.
// Reset: asynchronous, active low; parser hunts for sync, queue and output are empty.
// ----------------------------------------------------------------------------
// sync_length_frame_parser_with_ack
// Sync/length frame parser that passes frame bytes on and emits acknowledges.
// ----------------------------------------------------------------------------
module sync_length_frame_parser_with_ack import slfp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       frame_last,
	output logic       run_last
);

	logic wr_en;
	cmd_t wr_data;
	logic q_rd;
	cmd_t q_data;
	logic q_empty;

	slfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.rx_byte (rx_byte),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	slfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	slfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.frame_last (frame_last),
		.run_last   (run_last)
	);

endmodule
